### hw/rtl/sras_pkg.sv
// Shared types and constants of the SPI register access slave.
package sras_pkg;

   localparam int NUM_REGS  = 4;
   localparam int REG_BYTES = 8;
   localparam int RX_BYTES  = 16;
   localparam int TX_BYTES  = 16;

   localparam int RX_AW  = $clog2(RX_BYTES);
   localparam int TX_AW  = $clog2(TX_BYTES);
   localparam int REG_AW = $clog2(NUM_REGS * REG_BYTES);

   localparam logic [2:0] CMD_RX_BYTE   = 3'd0;
   localparam logic [2:0] CMD_TX_SLOT   = 3'd1;
   localparam logic [2:0] CMD_FRAME_END = 3'd2;
   localparam logic [2:0] CMD_LOCAL_WR  = 3'd3;
   localparam logic [2:0] CMD_LOCAL_RD  = 3'd4;

   localparam logic [7:0] CSR_READ_MASK  = 8'd0;
   localparam logic [7:0] CSR_WRITE_MASK = 8'd1;
   localparam logic [7:0] CSR_LEN_ZERO   = 8'd2;
   localparam logic [7:0] CSR_LEN_ONE    = 8'd3;
   localparam logic [7:0] CSR_LEN_TWO    = 8'd4;
   localparam logic [7:0] CSR_LEN_THREE  = 8'd5;
   localparam logic [7:0] CSR_WRITE_CODE = 8'd6;
   localparam logic [7:0] CSR_READ_CODE  = 8'd7;

   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_BAD_REG    = 2'd1;
   localparam logic [1:0] ST_BAD_ACCESS = 2'd2;
   localparam logic [1:0] ST_BAD_CMD    = 2'd3;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_DECODE,
      SEQ_HDR_STATUS,
      SEQ_HDR_COUNT,
      SEQ_COPY,
      SEQ_RESP
   } sras_state_type;

endpackage

### hw/rtl/spi_register_access_slave_core.sv
// Top level of the SPI register access slave: frame decode, reply queue and register store.
//
// Items arrive on the req_ channel: received bytes, transmit slots, frame ends and
// local register reads and writes. Every accepted item yields exactly one beat on the
// rsp_ channel carrying the byte to send or read, the phase, the queued reply count
// and the last status. A frame end with a non-empty frame in idle phase starts a
// sequencer that decodes the header, pushes the reply header one byte per cycle and
// then moves one register byte per cycle before it enters the result state. Every
// other item goes from acceptance straight to the result state, where the result is
// registered. No new item is taken until the sequencer is back in idle. req_ready is
// high only while the sequencer is idle and the result register is empty or being
// drained; a stalled receiver therefore holds off the next item. Configuration beats
// on the csr_ channel are always taken.
// Synchronous reset clears the frame and register stores, the frame and reply counters,
// the phase, status and result valid flag, and loads the configuration defaults.
module spi_register_access_slave_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_cmd,
   input  logic [7:0] req_data_byte,
   input  logic [1:0] req_reg_sel,
   input  logic [2:0] req_byte_sel,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_phase,
   output logic [4:0] rsp_reply_left,
   output logic [1:0] rsp_last_status,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_index,
   input  logic [7:0] csr_data
);
   import sras_pkg::*;

   sras_state_type state_ff, state_in;

   logic [3:0] read_mask_ff, write_mask_ff;
   logic [3:0] len_ff [NUM_REGS];
   logic [7:0] write_code_ff, read_code_ff;

   logic [7:0] frame_store_ff [RX_BYTES];
   logic [7:0] reply_store_ff [TX_BYTES];
   logic [7:0] reg_store_ff [NUM_REGS * REG_BYTES];

   logic       phase_ff, phase_in;
   logic [4:0] frame_count_ff, frame_count_in;
   logic [4:0] reply_len_ff, reply_len_in;
   logic [4:0] reply_ptr_ff, reply_ptr_in;
   logic [1:0] status_ff, status_in;
   logic [7:0] ob_ff, ob_in;

   logic       is_write_ff, is_write_in;
   logic       is_read_ff, is_read_in;
   logic [7:0] byte1_ff, byte1_in;
   logic [7:0] byte2_ff, byte2_in;
   logic [1:0] idx_ff, idx_in;
   logic [3:0] copy_len_ff, copy_len_in;
   logic [3:0] copy_cnt_ff, copy_cnt_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_out_byte_ff;
   logic       rsp_phase_ff;
   logic [4:0] rsp_reply_left_ff;
   logic [1:0] rsp_last_status_ff;

   logic              frame_we;
   logic [RX_AW-1:0]  frame_waddr;
   logic              push_en;
   logic [7:0]        push_data;
   logic              reply_we;
   logic              reg_we;
   logic [REG_AW-1:0] reg_waddr;
   logic [7:0]        reg_wdata;
   logic [REG_AW-1:0] reg_raddr;
   logic [7:0]        reg_rdata;

   logic       accept;
   logic [7:0] dec_cmd, dec_id, dec_given;
   logic       dec_known;
   logic [1:0] dec_idx;
   logic [3:0] dec_len;

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == SEQ_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign reg_rdata = reg_store_ff[reg_raddr];
   assign reply_we  = push_en && (reply_len_ff < 5'(TX_BYTES));

   assign dec_cmd   = frame_store_ff[1];
   assign dec_id    = frame_store_ff[2];
   assign dec_given = frame_store_ff[3];
   assign dec_known = (dec_id != 8'd0) && (dec_id <= 8'(NUM_REGS));
   assign dec_idx   = dec_known ? 2'(dec_id - 8'd1) : 2'd0;
   assign dec_len   = (len_ff[dec_idx] > 4'(REG_BYTES)) ? 4'(REG_BYTES) : len_ff[dec_idx];

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_out_byte_ff;
   assign rsp_phase       = rsp_phase_ff;
   assign rsp_reply_left  = rsp_reply_left_ff;
   assign rsp_last_status = rsp_last_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         read_mask_ff  <= 4'hF;
         write_mask_ff <= 4'hF;
         for (int r = 0; r < NUM_REGS; r++) begin
            len_ff[r] <= 4'd8;
         end
         write_code_ff <= 8'd1;
         read_code_ff  <= 8'd2;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_READ_MASK:  read_mask_ff  <= csr_data[3:0];
            CSR_WRITE_MASK: write_mask_ff <= csr_data[3:0];
            CSR_LEN_ZERO:   len_ff[0]     <= csr_data[3:0];
            CSR_LEN_ONE:    len_ff[1]     <= csr_data[3:0];
            CSR_LEN_TWO:    len_ff[2]     <= csr_data[3:0];
            CSR_LEN_THREE:  len_ff[3]     <= csr_data[3:0];
            CSR_WRITE_CODE: write_code_ff <= csr_data;
            CSR_READ_CODE:  read_code_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= 1'b0;
         frame_count_ff <= 5'd0;
         reply_len_ff   <= 5'd0;
         reply_ptr_ff   <= 5'd0;
         status_ff      <= ST_OK;
         rsp_valid_ff   <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         frame_count_ff <= frame_count_in;
         reply_len_ff   <= reply_len_in;
         reply_ptr_ff   <= reply_ptr_in;
         status_ff      <= status_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ob_ff       <= ob_in;
      is_write_ff <= is_write_in;
      is_read_ff  <= is_read_in;
      byte1_ff    <= byte1_in;
      byte2_ff    <= byte2_in;
      idx_ff      <= idx_in;
      copy_len_ff <= copy_len_in;
      copy_cnt_ff <= copy_cnt_in;
      if (state_ff == SEQ_RESP) begin
         rsp_out_byte_ff    <= ob_ff;
         rsp_phase_ff       <= phase_ff;
         rsp_reply_left_ff  <= reply_len_ff - reply_ptr_ff;
         rsp_last_status_ff <= status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < RX_BYTES; i++) begin
            frame_store_ff[i] <= 8'd0;
         end
      end else if (frame_we) begin
         frame_store_ff[frame_waddr] <= req_data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reply_we) begin
         reply_store_ff[reply_len_ff[TX_AW-1:0]] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS * REG_BYTES; i++) begin
            reg_store_ff[i] <= 8'd0;
         end
      end else if (reg_we) begin
         reg_store_ff[reg_waddr] <= reg_wdata;
      end
   end

   always_comb begin
      state_in       = state_ff;
      phase_in       = phase_ff;
      frame_count_in = frame_count_ff;
      reply_len_in   = reply_len_ff;
      reply_ptr_in   = reply_ptr_ff;
      status_in      = status_ff;
      ob_in          = ob_ff;
      is_write_in    = is_write_ff;
      is_read_in     = is_read_ff;
      byte1_in       = byte1_ff;
      byte2_in       = byte2_ff;
      idx_in         = idx_ff;
      copy_len_in    = copy_len_ff;
      copy_cnt_in    = copy_cnt_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      frame_we       = 1'b0;
      frame_waddr    = frame_count_ff[RX_AW-1:0];
      push_en        = 1'b0;
      push_data      = 8'd0;
      reg_we         = 1'b0;
      reg_waddr      = {req_reg_sel, req_byte_sel};
      reg_wdata      = req_data_byte;
      reg_raddr      = {req_reg_sel, req_byte_sel};

      unique case (state_ff)
         SEQ_IDLE: begin
            if (accept) begin
               ob_in    = 8'd0;
               state_in = SEQ_RESP;
               case (req_cmd)
                  CMD_RX_BYTE: begin
                     if (frame_count_ff < 5'(RX_BYTES)) begin
                        frame_we       = 1'b1;
                        frame_count_in = frame_count_ff + 5'd1;
                     end
                  end
                  CMD_TX_SLOT: begin
                     if (reply_len_ff != 5'd0) begin
                        ob_in = (reply_ptr_ff < 5'(TX_BYTES)) ?
                                reply_store_ff[reply_ptr_ff[TX_AW-1:0]] : 8'd0;
                        if (reply_ptr_ff + 5'd1 >= reply_len_ff) begin
                           reply_len_in = 5'd0;
                           reply_ptr_in = 5'd0;
                        end else begin
                           reply_ptr_in = reply_ptr_ff + 5'd1;
                        end
                     end
                  end
                  CMD_FRAME_END: begin
                     if (frame_count_ff != 5'd0) begin
                        frame_count_in = 5'd0;
                        if (!phase_ff) begin
                           state_in = SEQ_DECODE;
                        end else if (reply_len_ff == 5'd0) begin
                           phase_in = 1'b0;
                        end
                     end
                  end
                  CMD_LOCAL_WR: begin
                     reg_we = 1'b1;
                  end
                  CMD_LOCAL_RD: begin
                     ob_in = reg_rdata;
                  end
                  default: ;
               endcase
            end
         end
         SEQ_DECODE: begin
            phase_in     = 1'b1;
            reply_ptr_in = 5'd0;
            reply_len_in = 5'd1;
            push_en      = 1'b1;
            push_data    = frame_store_ff[0];
            idx_in       = dec_idx;
            copy_len_in  = 4'd0;
            is_write_in  = 1'b0;
            is_read_in   = 1'b0;
            byte2_in     = 8'd0;
            if (dec_cmd == write_code_ff) begin
               if (!dec_known) begin
                  status_in = ST_BAD_REG;
               end else if (!write_mask_ff[dec_idx] || dec_given != 8'(dec_len)) begin
                  status_in = ST_BAD_ACCESS;
               end else begin
                  status_in   = ST_OK;
                  is_write_in = 1'b1;
                  copy_len_in = dec_len;
               end
               byte1_in = 8'(status_in);
            end else if (dec_cmd == read_code_ff) begin
               if (!dec_known) begin
                  status_in = ST_BAD_REG;
                  byte1_in  = 8'(ST_BAD_REG);
               end else if (!read_mask_ff[dec_idx]) begin
                  status_in = ST_BAD_ACCESS;
                  byte1_in  = 8'(ST_BAD_ACCESS);
               end else begin
                  status_in   = ST_OK;
                  byte1_in    = 8'd0;
                  byte2_in    = 8'(dec_len);
                  is_read_in  = 1'b1;
                  copy_len_in = dec_len;
               end
            end else begin
               status_in = ST_BAD_CMD;
               byte1_in  = 8'(ST_BAD_CMD);
            end
            state_in = SEQ_HDR_STATUS;
         end
         SEQ_HDR_STATUS: begin
            push_en   = 1'b1;
            push_data = byte1_ff;
            state_in  = SEQ_HDR_COUNT;
         end
         SEQ_HDR_COUNT: begin
            push_en     = 1'b1;
            push_data   = byte2_ff;
            copy_cnt_in = 4'd0;
            state_in    = SEQ_COPY;
         end
         SEQ_COPY: begin
            reg_raddr = {idx_ff, copy_cnt_ff[2:0]};
            reg_waddr = {idx_ff, copy_cnt_ff[2:0]};
            reg_wdata = frame_store_ff[RX_AW'(copy_cnt_ff + 4'd4)];
            if (copy_cnt_ff == copy_len_ff) begin
               state_in = SEQ_RESP;
            end else begin
               reg_we      = is_write_ff;
               push_en     = is_read_ff;
               push_data   = reg_rdata;
               copy_cnt_in = copy_cnt_ff + 4'd1;
            end
         end
         SEQ_RESP: begin
            rsp_valid_in = 1'b1;
            state_in     = SEQ_IDLE;
         end
         default: state_in = SEQ_IDLE;
      endcase

      if (push_en && (reply_len_ff < 5'(TX_BYTES))) begin
         reply_len_in = reply_len_ff + 5'd1;
      end
   end

endmodule

### test/spi_register_access_slave_core_tb.sv
// Self-checking testbench of the SPI register access slave core with a built-in predictor.
module spi_register_access_slave_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sras_pkg::*;

   localparam logic [2:0] CMD_SPARE_LO = 3'd5;
   localparam logic [2:0] CMD_SPARE_HI = 3'd7;
   localparam int STALL_LIMIT = 3000;
   localparam int PHASE_ITEMS = 130;
   localparam int PHASE_COUNT = 6;

   typedef struct packed {
      logic [2:0] cmd;
      logic [7:0] data_byte;
      logic [1:0] reg_sel;
      logic [2:0] byte_sel;
   } spi_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       phase;
      logic [4:0] reply_left;
      logic [1:0] last_status;
   } spi_beat_type;

   typedef struct packed {
      spi_item_type item;
      bit           fixed;
      spi_beat_type fixed_beat;
   } spi_stim_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [2:0] req_cmd = '0;
   logic [7:0] req_data_byte = '0;
   logic [1:0] req_reg_sel = '0;
   logic [2:0] req_byte_sel = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_phase;
   logic [4:0] rsp_reply_left;
   logic [1:0] rsp_last_status;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [7:0] csr_index = '0;
   logic [7:0] csr_data = '0;

   spi_register_access_slave_core dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_cmd(req_cmd),
      .req_data_byte(req_data_byte),
      .req_reg_sel(req_reg_sel),
      .req_byte_sel(req_byte_sel),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_byte(rsp_out_byte),
      .rsp_phase(rsp_phase),
      .rsp_reply_left(rsp_reply_left),
      .rsp_last_status(rsp_last_status),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Configuration and state of the engine as the predictor sees it.
   logic [3:0]  rd_mask = 4'hF;
   logic [3:0]  wr_mask = 4'hF;
   logic [3:0]  reg_len [NUM_REGS] = '{4'd8, 4'd8, 4'd8, 4'd8};
   logic [7:0]  wr_code = 8'd1;
   logic [7:0]  rd_code = 8'd2;
   logic        phase_q = 1'b0;
   logic [7:0]  rx_frame [RX_BYTES] = '{default: 8'h00};
   int unsigned rx_count = 0;
   logic [7:0]  reply_buf [TX_BYTES] = '{default: 8'h00};
   int unsigned reply_n = 0;
   int unsigned reply_rd = 0;
   logic [7:0]  reg_file [NUM_REGS * REG_BYTES] = '{default: 8'h00};
   logic [1:0]  status_q = ST_OK;

   spi_stim_type stim_q [$];
   spi_beat_type due_beats [$];
   spi_stim_type cur_stim;
   spi_stim_type directed_rows [21];
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          hold_orders = 0;
   int          hold_served = 0;
   int          hold_left = 0;
   int          quiet_cycles = 0;
   int          queued = 0;
   int          items_accepted = 0;
   int          beats_checked = 0;
   int          mismatches = 0;
   int          frames_decoded = 0;
   int          spi_writes_done = 0;
   int          spi_reads_done = 0;
   int          settings_seen = 0;

   function automatic int unsigned eff_length(int unsigned idx);
      return (reg_len[idx] > REG_BYTES) ? REG_BYTES : reg_len[idx];
   endfunction

   function automatic void queue_reply_byte(logic [7:0] v);
      if (reply_n < TX_BYTES) begin
         reply_buf[reply_n] = v;
         reply_n++;
      end
   endfunction

   function automatic spi_beat_type apply_spi_item(spi_item_type it);
      spi_beat_type b;
      logic [7:0]  opcode;
      logic [7:0]  reg_id;
      logic [7:0]  given;
      bit          known;
      int unsigned idx;
      int unsigned n;
      int unsigned i;
      logic [1:0]  st;
      b.out_byte = 8'h00;
      case (it.cmd)
         CMD_RX_BYTE: begin
            if (rx_count < RX_BYTES) begin
               rx_frame[rx_count] = it.data_byte;
               rx_count++;
            end
         end
         CMD_TX_SLOT: begin
            if (reply_n != 0) begin
               b.out_byte = (reply_rd < TX_BYTES) ? reply_buf[reply_rd] : 8'h00;
               reply_rd++;
               if (reply_rd >= reply_n) begin
                  reply_n = 0;
                  reply_rd = 0;
               end
            end
         end
         CMD_FRAME_END: begin
            if (rx_count != 0) begin
               if (!phase_q) begin
                  opcode = rx_frame[1];
                  reg_id = rx_frame[2];
                  given = rx_frame[3];
                  known = reg_id >= 1 && reg_id <= NUM_REGS;
                  idx = known ? reg_id - 1 : 0;
                  n = eff_length(idx);
                  phase_q = 1'b1;
                  reply_n = 0;
                  reply_rd = 0;
                  frames_decoded++;
                  queue_reply_byte(rx_frame[0]);
                  if (opcode == wr_code) begin
                     if (!known) begin
                        st = ST_BAD_REG;
                     end else if (!wr_mask[idx]) begin
                        st = ST_BAD_ACCESS;
                     end else if (given != n) begin
                        st = ST_BAD_ACCESS;
                     end else begin
                        st = ST_OK;
                        spi_writes_done++;
                        for (i = 0; i < n; i++) begin
                           reg_file[idx * REG_BYTES + i] = rx_frame[4 + i];
                        end
                     end
                     queue_reply_byte({6'd0, st});
                     queue_reply_byte(8'h00);
                  end else if (opcode == rd_code) begin
                     if (!known || !rd_mask[idx]) begin
                        st = known ? ST_BAD_ACCESS : ST_BAD_REG;
                        queue_reply_byte({6'd0, st});
                        queue_reply_byte(8'h00);
                     end else begin
                        st = ST_OK;
                        spi_reads_done++;
                        queue_reply_byte(8'h00);
                        queue_reply_byte(n[7:0]);
                        for (i = 0; i < n; i++) begin
                           queue_reply_byte(reg_file[idx * REG_BYTES + i]);
                        end
                     end
                  end else begin
                     st = ST_BAD_CMD;
                     queue_reply_byte({6'd0, st});
                     queue_reply_byte(8'h00);
                  end
                  status_q = st;
               end else if (reply_n == 0) begin
                  phase_q = 1'b0;
               end
               rx_count = 0;
            end
         end
         CMD_LOCAL_WR: begin
            reg_file[it.reg_sel * REG_BYTES + it.byte_sel] = it.data_byte;
         end
         CMD_LOCAL_RD: begin
            b.out_byte = reg_file[it.reg_sel * REG_BYTES + it.byte_sel];
         end
         default: begin
         end
      endcase
      b.phase = phase_q;
      b.reply_left = 5'(reply_n - reply_rd);
      b.last_status = status_q;
      return b;
   endfunction

   function automatic spi_stim_type row(logic [2:0] c, logic [7:0] d, logic [1:0] rs,
                                        logic [2:0] bs, bit fx, logic [7:0] ob, logic ph,
                                        logic [4:0] rl, logic [1:0] st);
      spi_stim_type s;
      s.item = '{c, d, rs, bs};
      s.fixed = fx;
      s.fixed_beat = '{ob, ph, rl, st};
      return s;
   endfunction

   task automatic queue_item(logic [2:0] c, logic [7:0] d);
      spi_stim_type s;
      s.item.cmd = c;
      s.item.data_byte = d;
      s.item.reg_sel = 2'($urandom_range(0, 3));
      s.item.byte_sel = 3'($urandom_range(0, 7));
      s.fixed = 1'b0;
      s.fixed_beat = '0;
      stim_q.push_back(s);
      queued++;
   endtask

   // Mostly complete request frames with a drain and a closing frame, plus local traffic
   // and noise. Headers, lengths and payload sizes are bent now and then.
   task automatic queue_spi_transaction();
      int          kind;
      int          total;
      int          n_tx;
      int          r;
      int          i;
      bit          is_wr;
      logic [7:0]  opcode;
      logic [7:0]  reg_id;
      logic [7:0]  given;
      logic [7:0]  b;
      int unsigned idx;
      kind = $urandom_range(0, 99);
      if (kind < 12) begin
         repeat ($urandom_range(1, 4)) begin
            queue_item(3'($urandom_range(CMD_RX_BYTE, CMD_SPARE_HI)), 8'($urandom_range(0, 255)));
         end
         return;
      end
      if (kind < 25) begin
         repeat ($urandom_range(1, 6)) begin
            queue_item(($urandom_range(0, 1) != 0) ? CMD_LOCAL_WR : CMD_LOCAL_RD,
                       8'($urandom_range(0, 255)));
         end
         return;
      end
      is_wr = kind < 62;
      if ($urandom_range(0, 99) < 85) begin
         opcode = is_wr ? wr_code : rd_code;
      end else begin
         opcode = 8'($urandom_range(0, 255));
      end
      if ($urandom_range(0, 99) < 85) begin
         reg_id = 8'($urandom_range(1, NUM_REGS));
      end else begin
         reg_id = 8'($urandom_range(0, 255));
      end
      idx = (reg_id >= 1 && reg_id <= NUM_REGS) ? reg_id - 1 : 0;
      if ($urandom_range(0, 99) < 80) begin
         given = 8'(eff_length(idx));
      end else begin
         given = 8'($urandom_range(0, 15));
      end
      total = 4 + (is_wr ? int'(given) : 0);
      r = $urandom_range(0, 99);
      if (r < 10) begin
         total = $urandom_range(1, 3);
      end else if (r < 20) begin
         total = $urandom_range(RX_BYTES + 1, RX_BYTES + 4);
      end
      for (i = 0; i < total; i++) begin
         case (i)
            1: b = opcode;
            2: b = reg_id;
            3: b = given;
            default: b = 8'($urandom_range(0, 255));
         endcase
         queue_item(CMD_RX_BYTE, b);
      end
      queue_item(CMD_FRAME_END, 8'($urandom_range(0, 255)));
      n_tx = ($urandom_range(0, 99) < 85) ? 12 : $urandom_range(0, 12);
      repeat (n_tx) queue_item(CMD_TX_SLOT, 8'($urandom_range(0, 255)));
      r = $urandom_range(0, 99);
      if (r < 80) begin
         queue_item(CMD_RX_BYTE, 8'($urandom_range(0, 255)));
      end
      if (r < 90) begin
         queue_item(CMD_FRAME_END, 8'($urandom_range(0, 255)));
      end
   endtask

   task automatic wait_for_drain();
      do @(negedge clock); while (stim_q.size() != 0 || req_valid || due_beats.size() != 0);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_csr(logic [7:0] idx, logic [7:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_READ_MASK:  rd_mask = val[3:0];
         CSR_WRITE_MASK: wr_mask = val[3:0];
         CSR_LEN_ZERO:   reg_len[0] = val[3:0];
         CSR_LEN_ONE:    reg_len[1] = val[3:0];
         CSR_LEN_TWO:    reg_len[2] = val[3:0];
         CSR_LEN_THREE:  reg_len[3] = val[3:0];
         CSR_WRITE_CODE: wr_code = val;
         CSR_READ_CODE:  rd_code = val;
         default: begin
         end
      endcase
   endtask

   task automatic program_csrs(logic [7:0] rm, logic [7:0] wm, logic [7:0] l0, logic [7:0] l1,
                               logic [7:0] l2, logic [7:0] l3, logic [7:0] wc, logic [7:0] rc);
      write_csr(CSR_READ_MASK, rm);
      write_csr(CSR_WRITE_MASK, wm);
      write_csr(CSR_LEN_ZERO, l0);
      write_csr(CSR_LEN_ONE, l1);
      write_csr(CSR_LEN_TWO, l2);
      write_csr(CSR_LEN_THREE, l3);
      write_csr(CSR_WRITE_CODE, wc);
      write_csr(CSR_READ_CODE, rc);
      csr_valid <= 1'b0;
      settings_seen++;
   endtask

   task automatic note_mismatch(string what, spi_beat_type want, spi_beat_type got);
      if (mismatches < 10) begin
         $display("%s at beat %0d: expected %02h/%0d/%0d/%0d, got %02h/%0d/%0d/%0d",
                  what, beats_checked, want.out_byte, want.phase, want.reply_left,
                  want.last_status, got.out_byte, got.phase, got.reply_left, got.last_status);
      end
      mismatches++;
   endtask

   always @(posedge clock) begin : req_side
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            items_accepted++;
            if (cur_stim.fixed) begin
               void'(apply_spi_item(cur_stim.item));
               due_beats.push_back(cur_stim.fixed_beat);
            end else begin
               due_beats.push_back(apply_spi_item(cur_stim.item));
            end
         end
         if (!req_valid || req_ready) begin
            if (stim_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               cur_stim = stim_q.pop_front();
               req_valid <= 1'b1;
               req_cmd <= cur_stim.item.cmd;
               req_data_byte <= cur_stim.item.data_byte;
               req_reg_sel <= cur_stim.item.reg_sel;
               req_byte_sel <= cur_stim.item.byte_sel;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_side
      spi_beat_type got;
      spi_beat_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_out_byte, rsp_phase, rsp_reply_left, rsp_last_status};
            if (due_beats.size() == 0) begin
               note_mismatch("Unexpected beat", '0, got);
            end else begin
               want = due_beats.pop_front();
               if (got.out_byte !== want.out_byte || got.phase !== want.phase ||
                   got.reply_left !== want.reply_left ||
                   got.last_status !== want.last_status) begin
                  note_mismatch("Mismatch", want, got);
               end
            end
            beats_checked++;
         end
         if (hold_served != hold_orders) begin
            hold_served = hold_orders;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Timeout: no beat moved for %0d cycles.", quiet_cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : main_flow
      int         p;
      logic [7:0] same_code;
      directed_rows = '{
         row(CMD_LOCAL_RD,  8'h00, 2'd0, 3'd0, 1'b1, 8'h00, 1'b0, 5'd0, ST_OK),
         row(CMD_TX_SLOT,   8'hFF, 2'd3, 3'd7, 1'b1, 8'h00, 1'b0, 5'd0, ST_OK),
         row(CMD_FRAME_END, 8'h00, 2'd0, 3'd0, 1'b1, 8'h00, 1'b0, 5'd0, ST_OK),
         row(CMD_SPARE_LO,  8'h5A, 2'd1, 3'd2, 1'b1, 8'h00, 1'b0, 5'd0, ST_OK),
         row(CMD_SPARE_HI,  8'hFF, 2'd3, 3'd7, 1'b1, 8'h00, 1'b0, 5'd0, ST_OK),
         row(CMD_LOCAL_WR,  8'hFF, 2'd3, 3'd7, 1'b1, 8'h00, 1'b0, 5'd0, ST_OK),
         row(CMD_LOCAL_RD,  8'h00, 2'd3, 3'd7, 1'b1, 8'hFF, 1'b0, 5'd0, ST_OK),
         row(CMD_RX_BYTE,   8'hFF, 2'd0, 3'd0, 1'b1, 8'h00, 1'b0, 5'd0, ST_OK),
         row(CMD_RX_BYTE,   8'h00, 2'd3, 3'd7, 1'b1, 8'h00, 1'b0, 5'd0, ST_OK),
         row(CMD_FRAME_END, 8'h00, 2'd0, 3'd0, 1'b1, 8'h00, 1'b1, 5'd3, ST_BAD_CMD),
         row(CMD_TX_SLOT,   8'h00, 2'd0, 3'd0, 1'b1, 8'hFF, 1'b1, 5'd2, ST_BAD_CMD),
         row(CMD_TX_SLOT,   8'h00, 2'd0, 3'd0, 1'b1, {6'd0, ST_BAD_CMD}, 1'b1, 5'd1,
             ST_BAD_CMD),
         row(CMD_TX_SLOT,   8'h00, 2'd0, 3'd0, 1'b1, 8'h00, 1'b1, 5'd0, ST_BAD_CMD),
         row(CMD_RX_BYTE,   8'h00, 2'd1, 3'd1, 1'b1, 8'h00, 1'b1, 5'd0, ST_BAD_CMD),
         row(CMD_FRAME_END, 8'h00, 2'd2, 3'd4, 1'b1, 8'h00, 1'b0, 5'd0, ST_BAD_CMD),
         row(CMD_RX_BYTE,   8'hA5, 2'd0, 3'd0, 1'b1, 8'h00, 1'b0, 5'd0, ST_BAD_CMD),
         row(CMD_RX_BYTE,   8'h01, 2'd0, 3'd0, 1'b1, 8'h00, 1'b0, 5'd0, ST_BAD_CMD),
         row(CMD_FRAME_END, 8'h00, 2'd0, 3'd0, 1'b1, 8'h00, 1'b1, 5'd3, ST_BAD_REG),
         row(CMD_RX_BYTE,   8'h55, 2'd1, 3'd5, 1'b0, 8'h00, 1'b0, 5'd0, ST_OK),
         row(CMD_FRAME_END, 8'h00, 2'd2, 3'd6, 1'b0, 8'h00, 1'b0, 5'd0, ST_OK),
         row(CMD_TX_SLOT,   8'h00, 2'd3, 3'd3, 1'b0, 8'h00, 1'b0, 5'd0, ST_OK)
      };
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 37;
      recv_idle_pct = 65;
      foreach (directed_rows[i]) stim_q.push_back(directed_rows[i]);
      wait_for_drain();
      for (p = 0; p < PHASE_COUNT; p++) begin
         if (p == 2) begin
            send_idle_pct = 65;
            recv_idle_pct = 37;
         end else if (p == 4) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         same_code = 8'($urandom_range(0, 255));
         case (p)
            0: program_csrs(8'd15, 8'd15, 8'd8, 8'd8, 8'd8, 8'd8, 8'd1, 8'd2);
            1: program_csrs(8'd0, 8'd15, 8'd0, 8'd1, 8'd7, 8'd8, 8'd255, 8'd0);
            2: program_csrs(8'd15, 8'd0, 8'd15, 8'd9, 8'd8, 8'd3, 8'd0, 8'd255);
            3: program_csrs(8'($urandom_range(0, 15)), 8'($urandom_range(0, 15)),
                            8'($urandom_range(0, 15)), 8'($urandom_range(0, 15)),
                            8'($urandom_range(0, 15)), 8'($urandom_range(0, 15)),
                            same_code, same_code);
            4: program_csrs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            default: program_csrs(8'd15, 8'd15, 8'd8, 8'd8, 8'd8, 8'd8, 8'd1, 8'd2);
         endcase
         if (p == 1) begin
            hold_orders++;
         end
         queued = 0;
         while (queued < PHASE_ITEMS) queue_spi_transaction();
         wait_for_drain();
      end
      $display("Covered %0d items and %0d beats under %0d register settings.",
               items_accepted, beats_checked, settings_seen);
      $display("Frames decoded: %0d, with %0d register writes and %0d register reads over SPI.",
               frames_decoded, spi_writes_done, spi_reads_done);
      if (due_beats.size() != 0) begin
         $display("%0d expected beats never arrived.", due_beats.size());
      end
      if (mismatches == 0 && due_beats.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
